### hdl/slcfp_pkg.sv
// Package for the sync/length/checksum frame parser.
// Holds reset values, register indexes, event codes and the result item type.
// No dependencies.
package slcfp_pkg;

  // Default payload limit handed to the top level
  localparam int PAYLOAD_LIMIT_DEF = 1024;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_OVERHEAD = 3'd4;

  // Register reset values
  localparam logic [7:0]  SYNC_FIRST_RST    = 8'hFA;
  localparam logic [7:0]  SYNC_SECOND_RST   = 8'hFB;
  localparam logic [15:0] TIMEOUT_MS_RST    = 16'd100;
  localparam logic [10:0] MAX_PAYLOAD_RST   = 11'd256;
  localparam logic [7:0]  BODY_OVERHEAD_RST = 8'd9;

  // Event codes of a result item
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PAYLOAD   = 3'd1;
  localparam logic [2:0] EV_GOOD      = 3'd2;
  localparam logic [2:0] EV_LEN_ERR   = 3'd3;
  localparam logic [2:0] EV_DLEN_ERR  = 3'd4;
  localparam logic [2:0] EV_CSUM_ERR  = 3'd5;

  // One result item
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  frame_action;
    logic [15:0] frame_resource;
    logic [31:0] frame_message_id;
    logic [10:0] frame_data_length;
    logic        timed_out;
    logic [15:0] error_total;
  } result_t;

endpackage

### hdl/sync_length_checksum_frame_parser.sv
// Top level of the sync/length/checksum frame parser.
// Depends on slcfp_pkg for reset values, register indexes, event codes and result type.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one received byte with its
//   millisecond timestamp per item. Every accepted item yields exactly one
//   result item on the output channel (out_valid / out_stall): an event code,
//   the streamed payload byte and its index, the header fields held for the
//   current frame, a timeout flag and the saturating error count.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
//   sync bytes, inter-byte timeout, maximum payload and body overhead; they
//   are taken in every cycle and belong in idle periods only.
// Timing:
//   The parse update is one pass of logic from the accepted byte and the
//   parser state into a result register (or the skid register while a result
//   waits), and one item is taken every cycle while in_stall is low.
//   A two-entry output stage (result register plus skid register) parts the
//   channels: in_stall rises only once both entries hold results, i.e. after
//   the receiver has stalled a waiting result while another item arrived.
// Reset:
//   rst_n low (synchronous) returns the parser to the first sync hunt, clears
//   held fields, timestamp and error count, restores register defaults and
//   empties the output stage.
module sync_length_checksum_frame_parser #(
  parameter int PAYLOAD_LIMIT = slcfp_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic [31:0]                      in_now_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_event_res,
  output logic [7:0]                       out_payload_byte,
  output logic [9:0]                       out_payload_index,
  output logic [7:0]                       out_frame_action,
  output logic [15:0]                      out_frame_resource,
  output logic [31:0]                      out_frame_message_id,
  output logic [10:0]                      out_frame_data_length,
  output logic                             out_timed_out,
  output logic [15:0]                      out_error_total,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Parse steps, one-hot
  typedef enum logic [8:0] {
    ST_SYNC0 = 9'b000000001,
    ST_SYNC1 = 9'b000000010,
    ST_LEN   = 9'b000000100,
    ST_ACT   = 9'b000001000,
    ST_RES   = 9'b000010000,
    ST_MID   = 9'b000100000,
    ST_DLEN  = 9'b001000000,
    ST_DATA  = 9'b010000000,
    ST_SUM   = 9'b100000000
  } step_t;

  localparam logic [15:0] LIMIT_W = 16'(PAYLOAD_LIMIT);

  // Configuration registers
  logic [7:0]  sync_first_r, sync_second_r, overhead_r;
  logic [15:0] timeout_r;
  logic [10:0] max_payload_r;

  // Parser state
  step_t       step_r, step_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [15:0] blen_r, blen_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  action_r, action_nxt;
  logic [15:0] resource_r, resource_nxt;
  logic [31:0] msg_id_r, msg_id_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [31:0] last_time_r;
  logic [15:0] err_cnt_r, err_cnt_nxt;

  // Output stage
  logic                 out_valid_r, skid_valid_r;
  slcfp_pkg::result_t   out_r, skid_r, res;

  // Combinational parse signals
  logic        in_acc, out_take;
  logic        tmo, err_hit;
  step_t       step_e;
  logic [10:0] pos_e, pos_inc, maxp;
  logic [15:0] blen_e, blen_full, dlen_full, dlen_sum;
  logic [16:0] blen_lim;
  logic [7:0]  sum_e, sum_add, pbyte;
  logic [9:0]  pidx;
  logic [2:0]  ev;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slcfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= slcfp_pkg::SYNC_SECOND_RST;
      timeout_r     <= slcfp_pkg::TIMEOUT_MS_RST;
      max_payload_r <= slcfp_pkg::MAX_PAYLOAD_RST;
      overhead_r    <= slcfp_pkg::BODY_OVERHEAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slcfp_pkg::REG_SYNC_FIRST:    sync_first_r  <= cfg_data[7:0];
        slcfp_pkg::REG_SYNC_SECOND:   sync_second_r <= cfg_data[7:0];
        slcfp_pkg::REG_TIMEOUT_MS:    timeout_r     <= cfg_data;
        slcfp_pkg::REG_MAX_PAYLOAD:   max_payload_r <= cfg_data[10:0];
        slcfp_pkg::REG_BODY_OVERHEAD: overhead_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective payload maximum: smaller of register and limit
  assign maxp = ({5'd0, max_payload_r} < LIMIT_W) ? max_payload_r : LIMIT_W[10:0];

  // Apply the inter-byte timeout before the byte is handled
  assign tmo    = (step_r != ST_SYNC0) && ((in_now_ms - last_time_r) > {16'd0, timeout_r});
  assign step_e = tmo ? ST_SYNC0 : step_r;
  assign pos_e  = tmo ? 11'd0 : pos_r;
  assign blen_e = tmo ? 16'd0 : blen_r;
  assign sum_e  = tmo ? 8'd0 : sum_r;

  assign sum_add   = sum_e + in_rx_byte;
  assign pos_inc   = pos_e + 11'd1;
  assign blen_full = {blen_e[15:8], in_rx_byte};
  assign blen_lim  = {6'd0, maxp} + {9'd0, overhead_r};
  assign dlen_full = {dlen_r[15:8], in_rx_byte};
  assign dlen_sum  = dlen_full + {8'd0, overhead_r};

  // Next parser state for the accepted byte
  always_comb begin
    step_nxt     = step_e;
    pos_nxt      = pos_e;
    blen_nxt     = blen_e;
    sum_nxt      = sum_e;
    action_nxt   = action_r;
    resource_nxt = resource_r;
    msg_id_nxt   = msg_id_r;
    dlen_nxt     = dlen_r;
    ev           = slcfp_pkg::EV_NONE;
    pbyte        = 8'd0;
    pidx         = 10'd0;
    err_hit      = tmo;
    unique case (step_e)
      ST_SYNC0: begin
        if (in_rx_byte == sync_first_r) begin
          action_nxt   = 8'd0;
          resource_nxt = 16'd0;
          msg_id_nxt   = 32'd0;
          dlen_nxt     = 16'd0;
          sum_nxt      = in_rx_byte;
          step_nxt     = ST_SYNC1;
        end
      end
      ST_SYNC1: begin
        if (in_rx_byte == sync_second_r) begin
          sum_nxt  = sum_add;
          step_nxt = ST_LEN;
          pos_nxt  = 11'd0;
        end else if (in_rx_byte == sync_first_r) begin
          // repeated first sync: restart checksum from this byte
          sum_nxt = in_rx_byte;
        end else begin
          step_nxt = ST_SYNC0;
          pos_nxt  = 11'd0;
          blen_nxt = 16'd0;
          sum_nxt  = 8'd0;
        end
      end
      ST_LEN: begin
        sum_nxt = sum_add;
        if (pos_e == 11'd0) begin
          blen_nxt = {in_rx_byte, 8'd0};
          pos_nxt  = 11'd1;
        end else if (blen_full < {8'd0, overhead_r} || {1'b0, blen_full} > blen_lim) begin
          ev       = slcfp_pkg::EV_LEN_ERR;
          err_hit  = 1'b1;
          step_nxt = ST_SYNC0;
          pos_nxt  = 11'd0;
          blen_nxt = 16'd0;
          sum_nxt  = 8'd0;
        end else begin
          blen_nxt = blen_full;
          pos_nxt  = 11'd0;
          step_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        sum_nxt    = sum_add;
        action_nxt = in_rx_byte;
        step_nxt   = ST_RES;
      end
      ST_RES: begin
        sum_nxt = sum_add;
        if (pos_e == 11'd0) begin
          resource_nxt = {in_rx_byte, 8'd0};
          pos_nxt      = 11'd1;
        end else begin
          resource_nxt = {resource_r[15:8], in_rx_byte};
          pos_nxt      = 11'd0;
          step_nxt     = ST_MID;
        end
      end
      ST_MID: begin
        sum_nxt    = sum_add;
        msg_id_nxt = {msg_id_r[23:0], in_rx_byte};
        if (pos_inc >= 11'd4) begin
          pos_nxt  = 11'd0;
          step_nxt = ST_DLEN;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      ST_DLEN: begin
        sum_nxt = sum_add;
        if (pos_e == 11'd0) begin
          dlen_nxt = {in_rx_byte, 8'd0};
          pos_nxt  = 11'd1;
        end else begin
          dlen_nxt = dlen_full;
          pos_nxt  = 11'd0;
          if (dlen_full > {5'd0, maxp} || dlen_sum != blen_e) begin
            ev       = slcfp_pkg::EV_DLEN_ERR;
            err_hit  = 1'b1;
            step_nxt = ST_SYNC0;
            blen_nxt = 16'd0;
            sum_nxt  = 8'd0;
          end else if (dlen_full == 16'd0) begin
            // empty payload: checksum byte follows directly
            step_nxt = ST_SUM;
          end else begin
            step_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        sum_nxt = sum_add;
        ev      = slcfp_pkg::EV_PAYLOAD;
        pbyte   = in_rx_byte;
        pidx    = pos_e[9:0];
        if ({5'd0, pos_inc} >= dlen_r) begin
          pos_nxt  = 11'd0;
          step_nxt = ST_SUM;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      ST_SUM: begin
        if (sum_e == in_rx_byte) begin
          ev = slcfp_pkg::EV_GOOD;
        end else begin
          ev      = slcfp_pkg::EV_CSUM_ERR;
          err_hit = 1'b1;
        end
        step_nxt = ST_SYNC0;
        pos_nxt  = 11'd0;
        blen_nxt = 16'd0;
        sum_nxt  = 8'd0;
      end
      default: begin
        step_nxt = ST_SYNC0;
        pos_nxt  = 11'd0;
        blen_nxt = 16'd0;
        sum_nxt  = 8'd0;
      end
    endcase
  end

  // Saturating error count
  assign err_cnt_nxt = (err_hit && err_cnt_r != 16'hFFFF) ? err_cnt_r + 16'd1 : err_cnt_r;

  // Assemble the result item
  always_comb begin
    res.event_res         = ev;
    res.payload_byte      = pbyte;
    res.payload_index     = pidx;
    res.frame_action      = action_nxt;
    res.frame_resource    = resource_nxt;
    res.frame_message_id  = msg_id_nxt;
    res.frame_data_length = dlen_nxt[10:0];
    res.timed_out         = tmo;
    res.error_total       = err_cnt_nxt;
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_SYNC0;
      pos_r       <= 11'd0;
      blen_r      <= 16'd0;
      sum_r       <= 8'd0;
      action_r    <= 8'd0;
      resource_r  <= 16'd0;
      msg_id_r    <= 32'd0;
      dlen_r      <= 16'd0;
      last_time_r <= 32'd0;
      err_cnt_r   <= 16'd0;
    end else if (in_acc) begin
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      blen_r      <= blen_nxt;
      sum_r       <= sum_nxt;
      action_r    <= action_nxt;
      resource_r  <= resource_nxt;
      msg_id_r    <= msg_id_nxt;
      dlen_r      <= dlen_nxt;
      last_time_r <= in_now_ms;
      err_cnt_r   <= err_cnt_nxt;
    end
  end

  // Output stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= in_acc;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output stage payload: move skid forward, or load the new result
  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (in_acc && out_valid_r && !out_take) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_res         = out_r.event_res;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_payload_index     = out_r.payload_index;
  assign out_frame_action      = out_r.frame_action;
  assign out_frame_resource    = out_r.frame_resource;
  assign out_frame_message_id  = out_r.frame_message_id;
  assign out_frame_data_length = out_r.frame_data_length;
  assign out_timed_out         = out_r.timed_out;
  assign out_error_total       = out_r.error_total;

  // A skid entry exists only behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without a result in the output register");

  // Error count moves up by at most one per cycle
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (err_cnt_r == $past(err_cnt_r) || err_cnt_r == $past(err_cnt_r) + 16'd1))
    else $error("error count jumped");

  // Checksum byte without timeout always ends the frame
  a_sum_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step_r == ST_SUM && !tmo) |=> step_r == ST_SYNC0)
    else $error("parser did not restart after checksum byte");

endmodule
